// ===== sv/crcd_pkg.sv =====
// Package for the CRC packet deframer: frame constants, CRC-16 byte update,
// word payload types. No dependencies.
package crcd_pkg;

   localparam logic [7:0]  SYNC_BYTE      = 8'h42;
   localparam logic [7:0]  BROADCAST_ADDR = 8'hff;
   localparam logic [15:0] CRC_POLY       = 16'h1021;

   localparam logic [7:0]  STATION_ADDR_RESET = 8'd254;
   localparam logic [15:0] MAX_LEN_RESET      = 16'd280;

   // Register indexes on the csr port
   localparam logic CSR_STATION_ADDR = 1'b0;
   localparam logic CSR_MAX_LEN      = 1'b1;

   typedef enum logic [2:0] {
      VERDICT_NONE     = 3'd0,
      VERDICT_ACCEPT   = 3'd1,
      VERDICT_ADDR_ERR = 3'd2,
      VERDICT_CRC_ERR  = 3'd3,
      VERDICT_LEN_ERR  = 3'd4
   } verdict_type;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_word_type;

   typedef struct packed {
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic [15:0] payload_index;
      logic        frame_end;
      verdict_type verdict;
      logic [7:0]  frame_type;
      logic [15:0] frame_len;
      logic [7:0]  frame_address;
      logic        is_broadcast;
   } rsp_word_type;

   // CRC-16, MSB first, one byte per call
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      logic        top;
      c = crc;
      for (int k = 0; k < 8; k++) begin
         top = c[15] ^ data[7-k];
         c   = {c[14:0], 1'b0};
         if (top) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   // CRC after the sync byte alone
   localparam logic [15:0] CRC_AFTER_SYNC = crc_byte(16'h0000, SYNC_BYTE);

endpackage

// ===== sv/crcd_req_if.sv =====
// Request channel of the deframer: one received byte per word.
// Depends on crcd_pkg.
interface crcd_req_if import crcd_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/crcd_rsp_if.sv =====
// Response channel of the deframer: one parse result per word.
// Depends on crcd_pkg.
interface crcd_rsp_if import crcd_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/crc_packet_deframer_core.sv =====
// Top level of the CRC packet deframer: byte parser, running CRC-16, verdict.
// Depends on crcd_pkg, crcd_req_if and crcd_rsp_if.
//
//   channel | direction | word
//   --------+-----------+-----------------------------------------------------
//   req     | in        | rx_byte, one serial byte
//   rsp     | out       | payload byte/index, frame_end, verdict, header fields
//   csr     | in        | write enable, index, 16-bit data (address, max length)
//
// Each byte passes through the input register, then through the parse step
// into the result register. One byte a cycle is sustained while rsp does not
// stall. Reset is synchronous and active high; it restores the register
// defaults and puts the parser in idle. A stall on rsp holds the result
// register, and req drops ready once the input register also holds a byte.
module crc_packet_deframer_core import crcd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   crcd_req_if.sink    req,
   crcd_rsp_if.source  rsp,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   typedef enum logic [2:0] {
      PH_IDLE, PH_HEADER, PH_LEN_LO, PH_LEN_HI, PH_TYPE, PH_DATA, PH_CRC_LO, PH_CRC_HI
   } phase_type;

   // Configuration
   logic [7:0]  station_addr_ff;
   logic [15:0] max_len_ff;

   // Input register
   logic        stage_vld_ff, stage_vld_in;
   logic [7:0]  stage_byte_ff;

   // Parser state
   phase_type   phase_ff, phase_in;
   logic [7:0]  addr_ff, addr_in;
   logic [15:0] len_ff, len_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;

   // Result register
   logic         rsp_vld_ff, rsp_vld_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic        out_free;
   logic        advance;
   logic        req_take;
   logic [7:0]  b;
   logic [15:0] crc_upd;
   logic [15:0] new_len;
   logic [15:0] count_inc;
   logic [15:0] rx_crc;

   // A byte moves from the input register to the result register when the
   // result register is empty or being drained this cycle.
   assign out_free  = !rsp_vld_ff || rsp.ready;
   assign advance   = stage_vld_ff && out_free;
   assign req.ready = !stage_vld_ff || out_free;
   assign req_take  = req.valid && req.ready;

   assign rsp.valid   = rsp_vld_ff;
   assign rsp.payload = rsp_word_ff;

   assign b         = stage_byte_ff;
   assign crc_upd   = crc_byte(crc_ff, b);
   assign new_len   = {b, len_ff[7:0]};
   assign count_inc = count_ff + 16'd1;
   assign rx_crc    = {b, crc_lo_ff};

   always_comb begin
      phase_in  = phase_ff;
      addr_in   = addr_ff;
      len_in    = len_ff;
      type_in   = type_ff;
      count_in  = count_ff;
      crc_in    = crc_ff;
      crc_lo_in = crc_lo_ff;

      rsp_word_in               = '0;
      rsp_word_in.verdict       = VERDICT_NONE;

      case (phase_ff)
         PH_IDLE: begin
            if (b == SYNC_BYTE) begin
               addr_in  = '0;
               len_in   = '0;
               type_in  = '0;
               count_in = '0;
               crc_in   = CRC_AFTER_SYNC;
               phase_in = PH_HEADER;
            end
         end
         PH_HEADER: begin
            // a repeated sync keeps waiting for the address
            if (b != SYNC_BYTE) begin
               addr_in  = b;
               crc_in   = crc_byte(CRC_AFTER_SYNC, b);
               phase_in = PH_LEN_LO;
            end
         end
         PH_LEN_LO: begin
            len_in   = {8'h00, b};
            crc_in   = crc_upd;
            phase_in = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            len_in = new_len;
            crc_in = crc_upd;
            // drop an oversize frame right here
            if (new_len > max_len_ff) begin
               rsp_word_in.frame_end = 1'b1;
               rsp_word_in.verdict   = VERDICT_LEN_ERR;
               phase_in              = PH_IDLE;
            end else begin
               phase_in = PH_TYPE;
            end
         end
         PH_TYPE: begin
            type_in  = b;
            crc_in   = crc_upd;
            count_in = '0;
            phase_in = (len_ff != 16'd0) ? PH_DATA : PH_CRC_LO;
         end
         PH_DATA: begin
            rsp_word_in.payload_valid = 1'b1;
            rsp_word_in.payload_byte  = b;
            rsp_word_in.payload_index = count_ff;
            crc_in   = crc_upd;
            count_in = count_inc;
            if (count_inc >= len_ff) begin
               phase_in = PH_CRC_LO;
            end
         end
         PH_CRC_LO: begin
            crc_lo_in = b;
            phase_in  = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            // address is judged before the CRC
            rsp_word_in.frame_end = 1'b1;
            if (addr_ff != station_addr_ff && addr_ff != BROADCAST_ADDR) begin
               rsp_word_in.verdict = VERDICT_ADDR_ERR;
            end else if (rx_crc != crc_ff) begin
               rsp_word_in.verdict = VERDICT_CRC_ERR;
            end else begin
               rsp_word_in.verdict = VERDICT_ACCEPT;
            end
            phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      rsp_word_in.frame_type    = type_in;
      rsp_word_in.frame_len     = len_in;
      rsp_word_in.frame_address = addr_in;
      rsp_word_in.is_broadcast  = (addr_in == BROADCAST_ADDR);
   end

   assign stage_vld_in = req_take || (stage_vld_ff && !out_free);
   assign rsp_vld_in   = advance || (rsp_vld_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         station_addr_ff <= STATION_ADDR_RESET;
         max_len_ff      <= MAX_LEN_RESET;
         stage_vld_ff    <= 1'b0;
         rsp_vld_ff      <= 1'b0;
         phase_ff        <= PH_IDLE;
         addr_ff         <= '0;
         len_ff          <= '0;
         type_ff         <= '0;
         count_ff        <= '0;
         crc_ff          <= '0;
         crc_lo_ff       <= '0;
      end else begin
         // configuration writes take effect at once
         if (csr_write_en) begin
            case (csr_index)
               CSR_STATION_ADDR: station_addr_ff <= csr_wdata[7:0];
               CSR_MAX_LEN:      max_len_ff      <= csr_wdata;
               default:          max_len_ff      <= max_len_ff;
            endcase
         end
         stage_vld_ff <= stage_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
         // advance the parser only when the word moves into the result register
         if (advance) begin
            phase_ff  <= phase_in;
            addr_ff   <= addr_in;
            len_ff    <= len_in;
            type_ff   <= type_in;
            count_ff  <= count_in;
            crc_ff    <= crc_in;
            crc_lo_ff <= crc_lo_in;
         end
      end
      if (req_take) begin
         stage_byte_ff <= req.payload.rx_byte;
      end
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule

// ===== test/tb.sv =====
// Self-checking bench for crc_packet_deframer_core: drives received bytes, checks
// every parse result against an in-bench frame parser with its own CRC-16.
// Depends on crcd_pkg, crcd_req_if, crcd_rsp_if and the core itself.
module tb;
   import crcd_pkg::*;

   // Parser position within a frame
   typedef enum logic [2:0] {
      AWAIT_SYNC,
      AT_ADDRESS,
      AT_LEN_LO,
      AT_LEN_HI,
      AT_TYPE,
      IN_PAYLOAD,
      AT_CRC_LO,
      AT_CRC_HI
   } parse_phase_type;

   // Tracks the frame parser state and holds the parse results still awaited.
   class deframe_tracker;
      logic [7:0]      station;
      logic [15:0]     max_len;
      parse_phase_type phase;
      logic [7:0]      addr_r;
      logic [7:0]      type_r;
      logic [7:0]      crc_lo_r;
      logic [15:0]     len_r;
      logic [15:0]     count_r;
      logic [15:0]     crc_r;
      rsp_word_type    awaited[$];
      int              errors;

      function new();
         station  = STATION_ADDR_RESET;
         max_len  = MAX_LEN_RESET;
         phase    = AWAIT_SYNC;
         addr_r   = '0;
         type_r   = '0;
         crc_lo_r = '0;
         len_r    = '0;
         count_r  = '0;
         crc_r    = '0;
         errors   = 0;
      endfunction

      // CRC-16/0x1021, MSB first: fold the byte into the top, then shift eight times
      static function logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
         logic [15:0] c;
         c = crc ^ {b, 8'h00};
         for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
         end
         return c;
      endfunction

      // Advance the parser by one accepted byte and queue the result it causes
      function void take_byte(logic [7:0] b);
         rsp_word_type w;
         logic [15:0]  rx_crc;
         w = '0;
         w.verdict = VERDICT_NONE;
         case (phase)
            AWAIT_SYNC: begin
               if (b == SYNC_BYTE) begin
                  addr_r  = '0;
                  len_r   = '0;
                  type_r  = '0;
                  count_r = '0;
                  crc_r   = crc16_step(16'h0000, SYNC_BYTE);
                  phase   = AT_ADDRESS;
               end
            end
            AT_ADDRESS: begin
               // another sync here restarts the frame; stay in the address slot
               if (b != SYNC_BYTE) begin
                  addr_r = b;
                  crc_r  = crc16_step(crc16_step(16'h0000, SYNC_BYTE), b);
                  phase  = AT_LEN_LO;
               end
            end
            AT_LEN_LO: begin
               len_r = {8'h00, b};
               crc_r = crc16_step(crc_r, b);
               phase = AT_LEN_HI;
            end
            AT_LEN_HI: begin
               len_r = {b, len_r[7:0]};
               crc_r = crc16_step(crc_r, b);
               if (len_r > max_len) begin
                  w.frame_end = 1'b1;
                  w.verdict   = VERDICT_LEN_ERR;
                  phase       = AWAIT_SYNC;
               end else begin
                  phase = AT_TYPE;
               end
            end
            AT_TYPE: begin
               type_r  = b;
               crc_r   = crc16_step(crc_r, b);
               count_r = '0;
               phase   = (len_r > 0) ? IN_PAYLOAD : AT_CRC_LO;
            end
            IN_PAYLOAD: begin
               w.payload_valid = 1'b1;
               w.payload_byte  = b;
               w.payload_index = count_r;
               crc_r   = crc16_step(crc_r, b);
               count_r = count_r + 16'd1;
               if (count_r >= len_r) begin
                  phase = AT_CRC_LO;
               end
            end
            AT_CRC_LO: begin
               crc_lo_r = b;
               phase    = AT_CRC_HI;
            end
            default: begin
               rx_crc      = {b, crc_lo_r};
               w.frame_end = 1'b1;
               if (addr_r != station && addr_r != BROADCAST_ADDR) begin
                  w.verdict = VERDICT_ADDR_ERR;
               end else if (rx_crc != crc_r) begin
                  w.verdict = VERDICT_CRC_ERR;
               end else begin
                  w.verdict = VERDICT_ACCEPT;
               end
               phase = AWAIT_SYNC;
            end
         endcase
         w.frame_type    = type_r;
         w.frame_len     = len_r;
         w.frame_address = addr_r;
         w.is_broadcast  = (addr_r == BROADCAST_ADDR);
         awaited.push_back(w);
      endfunction

      function void check_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
         end
      endfunction

      // Compare one delivered result with the oldest awaited one
      function void compare_parse(rsp_word_type got);
         rsp_word_type want;
         if (awaited.size() == 0) begin
            $error("result word arrived with no byte outstanding");
            errors++;
            return;
         end
         want = awaited.pop_front();
         check_field("payload_valid", 16'(want.payload_valid), 16'(got.payload_valid));
         check_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
         check_field("payload_index", want.payload_index, got.payload_index);
         check_field("frame_end", 16'(want.frame_end), 16'(got.frame_end));
         check_field("verdict", 16'(want.verdict), 16'(got.verdict));
         check_field("frame_type", 16'(want.frame_type), 16'(got.frame_type));
         check_field("frame_len", want.frame_len, got.frame_len);
         check_field("frame_address", 16'(want.frame_address), 16'(got.frame_address));
         check_field("is_broadcast", 16'(want.is_broadcast), 16'(got.is_broadcast));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_write_en;
   logic        csr_index;
   logic [15:0] csr_wdata;

   // Idle odds, in percent, per offered word for the sender and per cycle for the receiver
   int send_idle_pct;
   int recv_idle_pct;
   // Bump to ask the receiver for one long hold-off
   int hold_off_req;
   // All accepted words, and those the parser merely skips while idle
   int words_sent;
   int ignored_words;

   deframe_tracker sb = new();

   crcd_req_if req_ch ();
   crcd_rsp_if rsp_ch ();

   crc_packet_deframer_core dut (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

   // Offer one word; idle first at random, then hold it until the block takes it.
   task automatic send_byte(input logic [7:0] b);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.payload.rx_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      sb.take_byte(b);
      words_sent++;
   endtask

   // Send line noise between frames; never a sync byte, so the parser stays idle.
   task automatic send_noise(input int n);
      logic [7:0] b;
      repeat (n) begin
         b = 8'($urandom);
         if (b == SYNC_BYTE) begin
            b = b + 8'd1;
         end
         send_byte(b);
         ignored_words++;
      end
   endtask

   // Send one frame with a correct CRC xor'ed with crc_flip; stop after the
   // length when it is over the limit, since the block drops the frame there.
   task automatic send_frame(input logic [7:0] addr, input logic [15:0] len,
                             input logic [7:0] ftype, input logic [15:0] crc_flip,
                             input int extra_syncs);
      logic [15:0] crc;
      logic [7:0]  b;
      crc = deframe_tracker::crc16_step(16'h0000, SYNC_BYTE);
      send_byte(SYNC_BYTE);
      repeat (extra_syncs) send_byte(SYNC_BYTE);
      send_byte(addr);
      crc = deframe_tracker::crc16_step(crc, addr);
      send_byte(len[7:0]);
      crc = deframe_tracker::crc16_step(crc, len[7:0]);
      send_byte(len[15:8]);
      crc = deframe_tracker::crc16_step(crc, len[15:8]);
      if (len > sb.max_len) begin
         return;
      end
      send_byte(ftype);
      crc = deframe_tracker::crc16_step(crc, ftype);
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom);
         send_byte(b);
         crc = deframe_tracker::crc16_step(crc, b);
      end
      crc = crc ^ crc_flip;
      send_byte(crc[7:0]);
      send_byte(crc[15:8]);
   endtask

   // Pick a frame: mostly own or broadcast address, mostly short payloads,
   // some lengths at and just past the limit, some bad CRCs and repeated syncs.
   task automatic send_random_frame();
      logic [7:0]  addr;
      logic [15:0] len;
      logic [15:0] flip;
      int          r;
      int          syncs;
      r = $urandom_range(0, 99);
      if (r < 40 && sb.station != SYNC_BYTE) begin
         addr = sb.station;
      end else if (r < 65) begin
         addr = BROADCAST_ADDR;
      end else begin
         addr = 8'($urandom);
         // a sync in the address slot would shift the whole header
         if (addr == SYNC_BYTE) begin
            addr = ~addr;
         end
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         len = 16'($urandom_range(0, 16));
      end else if (r < 75) begin
         len = 16'($urandom_range(17, 64));
      end else if (r < 88) begin
         len = 16'($urandom);
      end else begin
         len = sb.max_len + 16'($urandom_range(0, 1));
      end
      // keep accepted payloads short so the run stays small
      if (len <= sb.max_len && len > 300) begin
         len = {11'd0, len[4:0]};
      end
      flip  = ($urandom_range(0, 99) < 15) ? 16'($urandom_range(1, 65535)) : 16'h0000;
      syncs = ($urandom_range(0, 99) < 10) ? $urandom_range(1, 3) : 0;
      send_frame(addr, len, 8'($urandom), flip, syncs);
   endtask

   // Drop valid and wait until every awaited result has come out.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Write both registers on back-to-back cycles; the block is idle here.
   task automatic load_settings(input logic [7:0] st, input logic [15:0] ml);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_STATION_ADDR;
      csr_wdata    <= {8'h00, st};
      @(posedge clock);
      csr_index    <= CSR_MAX_LEN;
      csr_wdata    <= ml;
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.station = st;
      sb.max_len = ml;
   endtask

   // Receiver: check each accepted result, then choose ready for the next cycle.
   // A hold-off request keeps ready low long enough to back up the input side.
   initial begin
      int hold_left;
      int hold_seen;
      hold_left   = 0;
      hold_seen   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            sb.compare_parse(rsp_ch.payload);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (hold_seen != hold_off_req) begin
            hold_seen = hold_off_req;
            hold_left = 80;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Main sequence: reset, directed frames, then six random stretches, each
   // with its own register settings and one of three idling patterns.
   initial begin
      int          seg_base;
      logic [7:0]  st;
      logic [15:0] ml;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      csr_write_en   = 1'b0;
      csr_index      = CSR_STATION_ADDR;
      csr_wdata      = '0;
      send_idle_pct  = 35;
      recv_idle_pct  = 72;
      hold_off_req   = 0;
      words_sent     = 0;
      ignored_words  = 0;
      reset          = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part, reset settings: noise at both byte extremes while idle,
      // repeated sync before an own-address frame, zero-length broadcast with a
      // bad CRC, an oversized length, and a frame wrong in address and CRC both.
      send_byte(8'h00);
      ignored_words++;
      send_byte(8'hff);
      ignored_words++;
      send_frame(STATION_ADDR_RESET, 16'd1, 8'h00, 16'h0000, 1);
      send_frame(BROADCAST_ADDR, 16'd0, 8'hff, 16'h8001, 0);
      send_frame(8'h10, 16'hffff, 8'h00, 16'h0000, 0);
      send_frame(8'h11, 16'd0, 8'h5a, 16'h0001, 0);

      for (int seg = 0; seg < 6; seg++) begin
         drain_results();
         case (seg)
            0: begin
               st = 8'h00;
               ml = 16'h0000;
            end
            1: begin
               st = 8'hff;
               ml = 16'hffff;
            end
            2: begin
               st = 8'($urandom);
               ml = 16'($urandom_range(0, 300));
            end
            3: begin
               st = 8'($urandom);
               ml = 16'd1;
            end
            4: begin
               st = 8'($urandom);
               ml = 16'hffff;
            end
            default: begin
               st = 8'($urandom);
               ml = 16'($urandom);
            end
         endcase
         // receiver-heavy idling first, then sender-heavy, then none
         send_idle_pct = (seg < 2) ? 35 : (seg < 4) ? 72 : 0;
         recv_idle_pct = (seg < 2) ? 72 : (seg < 4) ? 35 : 0;
         load_settings(st, ml);
         // stall the receiver while the sender keeps pushing
         if (seg == 2 || seg == 4) begin
            hold_off_req++;
         end
         seg_base = words_sent - ignored_words;
         while (words_sent - ignored_words - seg_base < 325) begin
            if ($urandom_range(0, 99) < 8) begin
               send_noise($urandom_range(1, 4));
            end else begin
               send_random_frame();
            end
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.awaited.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== crc_packet_deframer_core.f =====
sv/crcd_pkg.sv
sv/crcd_req_if.sv
sv/crcd_rsp_if.sv
sv/crc_packet_deframer_core.sv
test/tb.sv
